@@ sv/pcs_pkg.sv @@
// Package for the streaming Pearson correlation block.
// Holds the controller/datapath command and status types and shared codes.
// No dependencies.
package pcs_pkg;

  localparam int          Q_ONE      = 16384;
  localparam logic [3:0]  K_SQRT     = 4'd7;
  localparam logic [3:0]  K_DIV      = 4'd8;
  localparam logic [1:0]  ST_OK      = 2'd0;
  localparam logic [1:0]  ST_ZERO    = 2'd1;
  localparam logic [1:0]  ST_OVER    = 2'd2;

  typedef struct packed {
    logic       acc;       // accumulate the accepted pair
    logic       start;     // launch job k
    logic       cap;       // capture the finished job's result
    logic [3:0] k;         // 0..6 products, then square root, then divide
    logic       load_out;  // load output register and clear the sums
  } pcs_cmd_t;

  typedef struct packed {
    logic idle;
  } pcs_stat_t;

endpackage

@@ sv/pearson_correlation_stream.sv @@
// Top level of the streaming Pearson correlation block.
// Ties the controller (pcs_ctrl) to the datapath (pcs_datapath); uses pcs_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall): one paired sample per transaction,
//    x and y signed 16-bit, in_last_pair closing the set. Pairs stream in at
//    one per cycle while the block is accumulating.
//  - After the last pair is taken, in_stall stays high while the result is
//    computed: seven 64-bit products on a bit-serial multiplier, a restoring
//    square root of the 126-bit variance product and a 15-step restoring
//    divide. The serial multiplier takes most of the compute time.
//  - Result channel (out_valid / out_stall): one transaction per set with
//    correlation in Q1.14, status (0 ok, 1 zero variance, 2 too many pairs)
//    and the pair count. The result sits in an output register; the next
//    set may accumulate while it waits. If the receiver still stalls when
//    the following result is done, the block holds with in_stall high.
//  - Reset (rst_n low, synchronous) clears the sums, the count and both
//    handshakes. Sums also clear whenever a result is loaded.
module pearson_correlation_stream import pcs_pkg::*; #(
  parameter int MAX_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_x_sample,
  input  logic signed [15:0] in_y_sample,
  input  logic               in_last_pair,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_correlation,
  output logic [1:0]         out_status,
  output logic [12:0]        out_pair_count
);

  pcs_cmd_t  cmd;
  pcs_stat_t stat;

  pcs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_pair (in_last_pair),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  pcs_datapath #(.MAX_COUNT(MAX_COUNT)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_x_sample     (in_x_sample),
    .in_y_sample     (in_y_sample),
    .out_correlation (out_correlation),
    .out_status      (out_status),
    .out_pair_count  (out_pair_count)
  );

endmodule

@@ sv/pcs_ctrl.sv @@
// Controller for the streaming Pearson correlation block.
// Sequences accumulate, products, square root, divide and result hand-off.
// Depends on pcs_pkg.
module pcs_ctrl import pcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_pair,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  pcs_stat_t stat,
  output pcs_cmd_t  cmd
);

  localparam logic [1:0] S_ACC  = 2'd0;
  localparam logic [1:0] S_GO   = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [3:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, out_free;

  assign in_stall  = (state_r != S_ACC);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.acc       = accept;
    cmd.k         = k_r;
    unique case (state_r)
      S_ACC: begin
        if (accept && in_last_pair) begin
          k_nxt     = '0;
          state_nxt = S_GO;
        end
      end
      S_GO: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (stat.idle) begin
          cmd.cap = 1'b1;
          if (k_r == K_DIV) begin
            state_nxt = S_FIN;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = S_GO;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/pcs_datapath.sv @@
// Datapath for the streaming Pearson correlation block: running sums,
// serial multiplier, restoring square root and divider, output register.
// Depends on pcs_pkg.
module pcs_datapath import pcs_pkg::*; #(
  parameter int MAX_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pcs_cmd_t           cmd,
  output pcs_stat_t          stat,
  input  logic signed [15:0] in_x_sample,
  input  logic signed [15:0] in_y_sample,
  output logic signed [15:0] out_correlation,
  output logic [1:0]         out_status,
  output logic [12:0]        out_pair_count
);

  localparam int CW   = $clog2(MAX_COUNT + 1);
  localparam int SX_W = 16 + CW;
  localparam int SQ_W = 32 + CW;

  // running state
  logic [CW-1:0]          n_r;
  logic                   ovf_r;
  logic signed [SX_W-1:0] sx_r, sy_r;
  logic signed [SQ_W-1:0] sxx_r, syy_r, sxy_r;
  logic signed [31:0]     pxx, pyy, pxy;

  assign pxx = in_x_sample * in_x_sample;
  assign pyy = in_y_sample * in_y_sample;
  assign pxy = in_x_sample * in_y_sample;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      n_r   <= '0;
      ovf_r <= 1'b0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else if (cmd.acc) begin
      if (32'(n_r) >= 32'(MAX_COUNT)) begin
        ovf_r <= 1'b1;
      end else begin
        n_r   <= n_r + CW'(1);
        sx_r  <= sx_r + SX_W'(in_x_sample);
        sy_r  <= sy_r + SX_W'(in_y_sample);
        sxx_r <= sxx_r + SQ_W'(pxx);
        syy_r <= syy_r + SQ_W'(pyy);
        sxy_r <= sxy_r + SQ_W'(pxy);
      end
    end
  end

  // job engine
  logic               busy_r;
  logic [5:0]         cnt_r, cnt_last;
  logic [127:0]       prod_r;
  logic [63:0]        mcand_r;
  logic               mneg_r;
  logic signed [63:0] tmp_r, c_r, vx_r, vy_r;
  logic [125:0]       rad_r;
  logic [64:0]        srem_r;
  logic [62:0]        root_r;
  logic [63:0]        mag_r, drem_r;
  logic               cneg_r;
  logic [15:0]        q_r;

  logic signed [63:0] op_a, op_b;
  logic [63:0]        abs_a, abs_b;
  logic [64:0]        msum;
  logic [127:0]       pval;
  logic [66:0]        s_r2, s_trial;
  logic [63:0]        d_r2, d_ext;
  logic               d_bit;
  logic [15:0]        q_step;

  always_comb begin
    case (cmd.k)
      4'd0:    begin op_a = 64'(n_r); op_b = 64'(sxy_r); end
      4'd1:    begin op_a = 64'(sx_r); op_b = 64'(sy_r); end
      4'd2:    begin op_a = 64'(n_r); op_b = 64'(sxx_r); end
      4'd3:    begin op_a = 64'(sx_r); op_b = 64'(sx_r); end
      4'd4:    begin op_a = 64'(n_r); op_b = 64'(syy_r); end
      4'd5:    begin op_a = 64'(sy_r); op_b = 64'(sy_r); end
      default: begin op_a = vx_r; op_b = vy_r; end
    endcase
    abs_a = op_a[63] ? 64'(-op_a) : op_a;
    abs_b = op_b[63] ? 64'(-op_b) : op_b;
  end

  assign msum    = {1'b0, prod_r[127:64]} + (prod_r[0] ? {1'b0, mcand_r} : 65'd0);
  assign pval    = mneg_r ? 128'(-prod_r) : prod_r;
  assign s_r2    = {srem_r, rad_r[125:124]};
  assign s_trial = {2'b00, root_r, 2'b01};
  assign d_r2    = (cnt_r == 6'd0) ? mag_r : {drem_r[62:0], 1'b0};
  assign d_ext   = {1'b0, root_r};
  assign d_bit   = (d_r2 >= d_ext);
  always_comb begin
    q_step = (cnt_r == 6'd0) ? {15'd0, d_bit} : {q_r[14:0], d_bit};
    if (q_step > 16'(Q_ONE)) q_step = 16'(Q_ONE);
  end

  always_comb begin
    if (cmd.k == K_SQRT)     cnt_last = 6'd62;
    else if (cmd.k == K_DIV) cnt_last = 6'd14;
    else                     cnt_last = 6'd63;
  end

  assign stat.idle = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + 6'd1;
      if (cnt_r == cnt_last) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      if (cmd.k == K_SQRT) begin
        srem_r <= '0;
        root_r <= '0;
      end else if (cmd.k == K_DIV) begin
        cneg_r <= c_r[63];
        mag_r  <= c_r[63] ? 64'(-c_r) : c_r;
      end else begin
        mcand_r <= abs_a;
        prod_r  <= {64'd0, abs_b};
        mneg_r  <= op_a[63] ^ op_b[63];
      end
    end else if (busy_r) begin
      if (cmd.k == K_SQRT) begin
        if (s_r2 >= s_trial) begin
          srem_r <= 65'(s_r2 - s_trial);
          root_r <= {root_r[61:0], 1'b1};
        end else begin
          srem_r <= s_r2[64:0];
          root_r <= {root_r[61:0], 1'b0};
        end
        rad_r <= {rad_r[123:0], 2'b00};
      end else if (cmd.k == K_DIV) begin
        drem_r <= d_bit ? (d_r2 - d_ext) : d_r2;
        q_r    <= q_step;
      end else begin
        prod_r <= {msum, prod_r[63:1]};
      end
    end else if (cmd.cap) begin
      case (cmd.k)
        4'd0, 4'd2, 4'd4: tmp_r <= pval[63:0];
        4'd1:             c_r   <= tmp_r - pval[63:0];
        4'd3:             vx_r  <= tmp_r - pval[63:0];
        4'd5:             vy_r  <= tmp_r - pval[63:0];
        4'd6:             rad_r <= pval[125:0];
        default:          ;
      endcase
    end
  end

  // output register
  logic [31:0] n_ext;
  assign n_ext = 32'(n_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pair_count <= n_ext[12:0];
      if (ovf_r) begin
        out_status      <= ST_OVER;
        out_correlation <= '0;
      end else if (root_r == '0) begin
        out_status      <= ST_ZERO;
        out_correlation <= '0;
      end else begin
        out_status      <= ST_OK;
        out_correlation <= cneg_r ? 16'(-q_r) : q_r;
      end
    end
  end

endmodule

@@ verif/pearson_correlation_stream_tb.sv @@
// Self-checking testbench for pearson_correlation_stream.
// Predicts each set's correlation, status and pair count from the pairs that
// were accepted and checks every result in order; needs pcs_pkg and the RTL.
module pearson_correlation_stream_tb import pcs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_LIMIT   = 4096;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 700;   // a bit more than the result computation

  typedef struct {
    logic signed [15:0] corr;
    logic [1:0]         status;
    logic [12:0]        count;
  } corr_result_t;

  // Scoreboard: keeps running sums like the block, queues expected results.
  class corr_scoreboard;
    bit [63:0]    pairs, sum_x, sum_y, sum_xx, sum_yy, sum_xy;
    bit           ovf;
    corr_result_t pending[$];
    int           errors;
    int           results;

    function void clear_sums();
      pairs = 0; sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0;
      ovf = 0;
    endfunction

    function void note_pair(logic signed [15:0] x, logic signed [15:0] y,
                            logic last);
      longint       xs, ys;
      bit [63:0]    cov, vx, vy, dnm, mag, quo, rem, cand;
      bit [127:0]   prod;
      bit           neg;
      corr_result_t r;
      xs = x;
      ys = y;
      if (pairs >= SET_LIMIT) begin
        ovf = 1;
      end else begin
        pairs++;
        sum_x  += xs;
        sum_y  += ys;
        sum_xx += xs * xs;
        sum_yy += ys * ys;
        sum_xy += xs * ys;
      end
      if (!last) return;
      r.corr   = 0;
      r.status = ST_OK;
      r.count  = pairs[12:0];
      if (ovf) begin
        r.status = ST_OVER;
      end else begin
        cov  = pairs * sum_xy - sum_x * sum_y;
        vx   = pairs * sum_xx - sum_x * sum_x;
        vy   = pairs * sum_yy - sum_y * sum_y;
        prod = {64'd0, vx} * {64'd0, vy};
        dnm  = 0;
        // bitwise integer square root of the variance product
        for (int b = 62; b >= 0; b--) begin
          cand = dnm | (64'd1 << b);
          if ({64'd0, cand} * {64'd0, cand} <= prod) dnm = cand;
        end
        if (dnm == 0) begin
          r.status = ST_ZERO;
        end else begin
          neg = cov[63];
          mag = neg ? -cov : cov;
          quo = mag / dnm;
          rem = mag % dnm;
          for (int i = 0; i < 14; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= dnm) begin
              rem -= dnm;
              quo |= 1;
            end
            if (quo > Q_ONE) quo = Q_ONE;
          end
          if (quo > Q_ONE) quo = Q_ONE;
          r.corr = neg ? -quo[15:0] : quo[15:0];
        end
      end
      pending = {pending, r};
      clear_sums();
    endfunction

    function void check_result(logic signed [15:0] corr, logic [1:0] status,
                               logic [12:0] count);
      corr_result_t e;
      results++;
      if (pending.size() == 0) begin
        $error("unexpected result transaction: corr %0d status %0d count %0d",
               corr, status, count);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (corr !== e.corr) begin
        $error("correlation: expected %0d, got %0d", e.corr, corr);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (count !== e.count) begin
        $error("pair_count: expected %0d, got %0d", e.count, count);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [15:0] in_x_sample = 0;
  logic signed [15:0] in_y_sample = 0;
  logic               in_last_pair = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [15:0] out_correlation;
  logic [1:0]         out_status;
  logic [12:0]        out_pair_count;

  corr_scoreboard sb = new();
  int  send_idle_pct = 0;   // chance per cycle that the sender holds back
  int  stall_pct     = 0;   // chance per cycle that the receiver stalls
  int  hold_req      = 0;   // long receiver hold-off, loaded by its process
  int  hold_left     = 0;
  int  cycles        = 0;
  int  items         = 0;
  int  sets          = 0;

  pearson_correlation_stream #(.MAX_COUNT(SET_LIMIT)) uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[pearson_correlation_stream] ERROR");
      $finish;
    end
  end

  // Receiver: random stall, plus an occasional long hold so the block's
  // output register fills and in_stall backs up onto the sender.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Outputs are sampled mid-cycle, when they are stable, and the transaction
  // is counted at the following rising edge.
  logic               take_res = 0;
  logic signed [15:0] got_corr;
  logic [1:0]         got_status;
  logic [12:0]        got_count;

  always @(negedge clk) begin
    take_res   = rst_n && out_valid && !out_stall;
    got_corr   = out_correlation;
    got_status = out_status;
    got_count  = out_pair_count;
  end

  always @(posedge clk) begin
    if (take_res) sb.check_result(got_corr, got_status, got_count);
  end

  // One input transaction; returns after the edge that accepts it.
  task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y,
                           logic last);
    bit go;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid     <= 1'b0;
      in_x_sample  <= 16'($urandom);
      in_y_sample  <= 16'($urandom);
      in_last_pair <= 1'($urandom);
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_x_sample  <= x;
    in_y_sample  <= y;
    in_last_pair <= last;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
    sb.note_pair(x, y, last);
    items++;
    if (last) sets++;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return $signed(16'($urandom_range(15))) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // A set of n pairs with random content and a random x-y relationship.
  task automatic send_set(int n);
    logic signed [15:0] x, y;
    int                 mode;
    mode = $urandom_range(4);
    for (int i = 0; i < n; i++) begin
      x = pick_sample();
      case (mode)
        0:       y = x;
        1:       y = -x;
        2:       y = x + $signed(16'($urandom_range(63))) - 16'sd32;
        default: y = pick_sample();
      endcase
      send_pair(x, y, i == n - 1);
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  int target;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single pair (zero variance), extremes, perfect +/- correlation,
    // constant series.
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sd5, 16'sd1, 1'b0);
    send_pair(16'sd5, -16'sd7, 1'b0);
    send_pair(16'sd5, 16'sd9, 1'b1);
    send_pair(16'sd1, 16'sd3, 1'b0);
    send_pair(16'sd2, 16'sd1, 1'b0);
    send_pair(16'sd3, 16'sd4, 1'b0);
    send_pair(-16'sd4, 16'sd1, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(-16'sd1, -16'sd1, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);

    // Random sets under four idling patterns.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      if (ph == 2) hold_req = 3000;   // block fills up and stalls its input
      target = items + 185;
      while (items < target) begin
        case ($urandom_range(19))
          0:       send_set(1);
          1, 2, 3: send_set($urandom_range(13, 60));
          default: send_set($urandom_range(2, 12));
        endcase
      end
    end

    in_valid <= 1'b0;
    drain();

    $display("Covered %0d pairs in %0d sets, %0d results checked, incl. zero variance,",
             items, sets, sb.results);
    $display("extreme samples, constant series, stalls and a long hold-off.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[pearson_correlation_stream] OK");
    end else begin
      $display("[pearson_correlation_stream] ERROR");
    end
    $finish;
  end

endmodule
